### rtl/ffpsc_pkg.sv
// shared types and constants for the fixed frame parser with additive checksum
package ffpsc_pkg;

    localparam int unsigned DefFrameBytes = 16;
    localparam int unsigned HeaderBytes   = 5;
    localparam int unsigned PosW          = 6;

    localparam logic [PosW-1:0] PosTgtLo = PosW'(0);
    localparam logic [PosW-1:0] PosTgtHi = PosW'(1);
    localparam logic [PosW-1:0] PosSrcLo = PosW'(2);
    localparam logic [PosW-1:0] PosSrcHi = PosW'(3);
    localparam logic [PosW-1:0] PosCmd   = PosW'(4);

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_BAD   = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        t_kind           kind;
        logic [7:0]      payload_byte;
        logic [PosW-1:0] payload_index;
        logic [15:0]     target_id;
        logic [15:0]     source_id;
        logic [7:0]      command_code;
        t_status         status;
        logic            frame_last;
    } t_result;

endpackage

### rtl/ffpsc_in_stage.sv
// input register holding one accepted byte until the deframer takes it
module ffpsc_in_stage
    import ffpsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/ffpsc_core.sv
// frame position tracking, header capture, checksum and result forming
module ffpsc_core
    import ffpsc_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = DefFrameBytes
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    input  logic    i_out_free,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
    localparam logic [PosW-1:0] HdrLen  = PosW'(HeaderBytes);

    logic [PosW-1:0] r_pos, n_pos;
    logic            r_in_frame, n_in_frame;
    logic [7:0]      r_sum, n_sum;
    logic [15:0]     r_tgt, n_tgt;
    logic [15:0]     r_src, n_src;
    logic [7:0]      r_cmd, n_cmd;

    logic [PosW-1:0] pos;
    logic [7:0]      sum;
    logic [15:0]     tgt;
    logic [15:0]     src;
    logic [7:0]      cmd;
    logic            open;
    logic            trunc;
    logic [7:0]      b;

    always_comb begin
        b      = i_item.data_byte;
        trunc  = i_item.frame_start && r_in_frame;
        open   = i_item.frame_start || r_in_frame;
        pos    = i_item.frame_start ? '0 : r_pos;
        sum    = i_item.frame_start ? '0 : r_sum;
        tgt    = i_item.frame_start ? '0 : r_tgt;
        src    = i_item.frame_start ? '0 : r_src;
        cmd    = i_item.frame_start ? '0 : r_cmd;

        n_pos      = r_pos;
        n_in_frame = r_in_frame;
        n_sum      = r_sum;
        n_tgt      = r_tgt;
        n_src      = r_src;
        n_cmd      = r_cmd;

        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, status: ST_GOOD, default: '0};

        if (trunc) begin
            o_res_valid = 1'b1;
            o_res = '{kind: KIND_SUMMARY, payload_byte: '0, payload_index: '0,
                      target_id: r_tgt, source_id: r_src, command_code: r_cmd,
                      status: ST_TRUNC, frame_last: 1'b1};
        end

        if (open) begin
            n_in_frame = 1'b1;
            n_tgt      = tgt;
            n_src      = src;
            n_cmd      = cmd;
            if (pos >= LastPos) begin
                o_res_valid = 1'b1;
                o_res = '{kind: KIND_SUMMARY, payload_byte: '0, payload_index: '0,
                          target_id: tgt, source_id: src, command_code: cmd,
                          status: (b == sum) ? ST_GOOD : ST_BAD, frame_last: 1'b1};
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_sum      = '0;
            end else begin
                priority case (pos)
                    PosTgtLo: n_tgt = {8'h00, b};
                    PosTgtHi: n_tgt = {b, tgt[7:0]};
                    PosSrcLo: n_src = {8'h00, b};
                    PosSrcHi: n_src = {b, src[7:0]};
                    PosCmd:   n_cmd = b;
                    default: begin
                        o_res_valid = 1'b1;
                        o_res = '{kind: KIND_PAYLOAD, payload_byte: b,
                                  payload_index: pos - HdrLen, target_id: '0,
                                  source_id: '0, command_code: '0,
                                  status: ST_GOOD, frame_last: 1'b0};
                    end
                endcase
                n_sum = sum + b;
                n_pos = pos + PosW'(1);
            end
        end

        o_take = i_item_valid && (!o_res_valid || i_out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_sum      <= '0;
            r_tgt      <= '0;
            r_src      <= '0;
            r_cmd      <= '0;
        end else if (o_take) begin
            r_pos      <= n_pos;
            r_in_frame <= n_in_frame;
            r_sum      <= n_sum;
            r_tgt      <= n_tgt;
            r_src      <= n_src;
            r_cmd      <= n_cmd;
        end
    end

endmodule

### rtl/ffpsc_out_stage.sv
// result register on the output channel
module ffpsc_out_stage
    import ffpsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/fixed_frame_parser_sum_checksum_top.sv
// top level of the fixed-length frame parser with 8-bit additive checksum
//
// input channel: one received byte per transfer on i_valid / o_ready, with
// i_frame_start marking byte 0 of a frame of FRAME_BYTES bytes.
// output channel: o_valid / i_ready; o_kind 0 gives a payload byte and its
// index, o_kind 1 a frame summary (ids, command, status, o_frame_last set).
// header bytes and bytes outside a frame give no result.
// a byte is taken into an input register, decoded there and its result
// written to the output register, which drives o_valid. one byte per cycle
// is sustained while the receiver does not stall, set by the single
// decode step between the two registers.
// when the receiver stalls, the output register holds its result and a byte
// that yields no result still moves on; a byte with a result waits in the
// input register and o_ready drops once that register is full.
// reset clears both registers and the frame state: no frame is open.
module fixed_frame_parser_sum_checksum_top
    import ffpsc_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = DefFrameBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [5:0]  o_payload_index,
    output logic [15:0] o_target_id,
    output logic [15:0] o_source_id,
    output logic [7:0]  o_command_code,
    output logic [1:0]  o_status,
    output logic        o_frame_last
);

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item = '{data_byte: i_data_byte, frame_start: i_frame_start};

    ffpsc_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_take       (take),
        .o_item_valid (st_valid),
        .o_item       (st_item)
    );

    ffpsc_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (st_valid),
        .i_item       (st_item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    ffpsc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_target_id     = out_res.target_id;
    assign o_source_id     = out_res.source_id;
    assign o_command_code  = out_res.command_code;
    assign o_status        = out_res.status;
    assign o_frame_last    = out_res.frame_last;

endmodule

### tb/tb.sv
// testbench for the fixed frame parser: directed rows, then random frames checked by a predictor
`timescale 1ns / 100ps

module tb;
    import ffpsc_pkg::*;

    localparam int FRAME_BYTES  = DefFrameBytes;
    localparam int N_ITEMS      = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef enum {ROW_MODEL, ROW_NONE, ROW_TYPED} t_row_chk;

    typedef struct {
        logic [7:0] data;
        logic       start;
        t_row_chk   chk;
        t_result    res;
    } t_row;

    localparam t_result SUM_FIRST = '{kind: KIND_SUMMARY, payload_byte: 8'h00,
        payload_index: 6'd0, target_id: 16'hFFFF, source_id: 16'h0000,
        command_code: 8'h80, status: ST_GOOD, frame_last: 1'b1};
    localparam t_result TRUNC_TGT = '{kind: KIND_SUMMARY, payload_byte: 8'h00,
        payload_index: 6'd0, target_id: 16'h1234, source_id: 16'h0000,
        command_code: 8'h00, status: ST_TRUNC, frame_last: 1'b1};
    localparam t_result TRUNC_SRC = '{kind: KIND_SUMMARY, payload_byte: 8'h00,
        payload_index: 6'd0, target_id: 16'h0000, source_id: 16'h00AB,
        command_code: 8'h00, status: ST_TRUNC, frame_last: 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_frame_start;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [5:0]  o_payload_index;
    logic [15:0] o_target_id;
    logic [15:0] o_source_id;
    logic [7:0]  o_command_code;
    logic [1:0]  o_status;
    logic        o_frame_last;

    // predictor state
    logic [5:0]  rx_pos;
    logic        rx_open;
    logic [7:0]  rx_sum;
    logic [15:0] rx_target;
    logic [15:0] rx_source;
    logic [7:0]  rx_command;

    t_result     pending_results[$];
    t_row        dir_rows [0:22];
    int          mismatches;
    int          cycle_count;
    int          accepted_count;
    int          burst_left;
    bit          hold_req;

    fixed_frame_parser_sum_checksum_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_target_id    (o_target_id),
        .o_source_id    (o_source_id),
        .o_command_code (o_command_code),
        .o_status       (o_status),
        .o_frame_last   (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit deframe_byte(input logic [7:0] b, input logic s,
                                        output t_result r);
        bit got;
        got = 1'b0;
        r = '0;
        if (s) begin
            if (rx_open) begin
                r.kind         = KIND_SUMMARY;
                r.target_id    = rx_target;
                r.source_id    = rx_source;
                r.command_code = rx_command;
                r.status       = ST_TRUNC;
                r.frame_last   = 1'b1;
                got = 1'b1;
            end
            rx_open    = 1'b1;
            rx_pos     = '0;
            rx_sum     = '0;
            rx_target  = '0;
            rx_source  = '0;
            rx_command = '0;
        end
        if (!rx_open) begin
            return got;
        end
        if (rx_pos >= 6'(FRAME_BYTES - 1)) begin
            r = '0;
            r.kind         = KIND_SUMMARY;
            r.target_id    = rx_target;
            r.source_id    = rx_source;
            r.command_code = rx_command;
            r.status       = (b == rx_sum) ? ST_GOOD : ST_BAD;
            r.frame_last   = 1'b1;
            rx_open = 1'b0;
            rx_pos  = '0;
            rx_sum  = '0;
            return 1'b1;
        end
        case (rx_pos)
            PosTgtLo: begin
                rx_target = {8'h00, b};
            end
            PosTgtHi: begin
                rx_target[15:8] = b;
            end
            PosSrcLo: begin
                rx_source = {8'h00, b};
            end
            PosSrcHi: begin
                rx_source[15:8] = b;
            end
            PosCmd: begin
                rx_command = b;
            end
            default: begin
                r.kind          = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = rx_pos - 6'(HeaderBytes);
                got = 1'b1;
            end
        endcase
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 6'd1;
        return got;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom_range(0, 255));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic s, input t_row_chk chk,
                             input t_result typed);
        t_result r;
        bit got;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= s;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        got = deframe_byte(b, s, r);
        case (chk)
            ROW_MODEL: begin
                if (got) pending_results.push_back(r);
            end
            ROW_TYPED: begin
                pending_results.push_back(typed);
            end
            default: begin
            end
        endcase
    endtask

    task automatic offer(input logic [7:0] b, input logic s);
        if (burst_left == 0) begin
            idle_gap($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        if (s || rx_open) accepted_count++;
        send_byte(b, s, ROW_MODEL, '0);
    endtask

    task automatic send_frame(input int len, input bit good_sum);
        logic [7:0] sum8;
        logic [7:0] b;
        sum8 = '0;
        for (int i = 0; i < len; i++) begin
            b = rand_byte();
            if (i == FRAME_BYTES - 1) begin
                b = good_sum ? sum8 : sum8 ^ 8'($urandom_range(1, 255));
            end
            offer(b, i == 0);
            sum8 = sum8 + b;
        end
    endtask

    task automatic drain_wait();
        idle_gap(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic field_mismatch(input string name, input logic [15:0] want,
                                  input logic [15:0] seen);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        mismatches++;
    endtask

    // receiver stall pattern
    initial begin : rx_pattern
        int run_len;
        bit rdy;
        i_ready = 1'b0;
        rdy = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end
            rdy = !rdy;
            if (rdy) begin
                run_len = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            end else begin
                run_len = $urandom_range(1, 5);
            end
            repeat (run_len) begin
                @(negedge i_clk);
                i_ready <= rdy;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen.kind          = t_kind'(o_kind);
            seen.payload_byte  = o_payload_byte;
            seen.payload_index = o_payload_index;
            seen.target_id     = o_target_id;
            seen.source_id     = o_source_id;
            seen.command_code  = o_command_code;
            seen.status        = t_status'(o_status);
            seen.frame_last    = o_frame_last;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, seen);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind)
                    field_mismatch("kind", want.kind, seen.kind);
                if (seen.payload_byte !== want.payload_byte)
                    field_mismatch("payload_byte", want.payload_byte, seen.payload_byte);
                if (seen.payload_index !== want.payload_index)
                    field_mismatch("payload_index", want.payload_index, seen.payload_index);
                if (seen.target_id !== want.target_id)
                    field_mismatch("target_id", want.target_id, seen.target_id);
                if (seen.source_id !== want.source_id)
                    field_mismatch("source_id", want.source_id, seen.source_id);
                if (seen.command_code !== want.command_code)
                    field_mismatch("command_code", want.command_code, seen.command_code);
                if (seen.status !== want.status)
                    field_mismatch("status", want.status, seen.status);
                if (seen.frame_last !== want.frame_last)
                    field_mismatch("frame_last", want.frame_last, seen.frame_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fixed_frame_parser_sum_checksum_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        bit hold_done;
        bit pause_done;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        accepted_count = 0;
        burst_left    = 0;
        rx_pos        = '0;
        rx_open       = 1'b0;
        rx_sum        = '0;
        rx_target     = '0;
        rx_source     = '0;
        rx_command    = '0;

        dir_rows = '{
            '{8'hAA, 1'b0, ROW_NONE,  '0},
            '{8'hFF, 1'b1, ROW_MODEL, '0},
            '{8'hFF, 1'b0, ROW_MODEL, '0},
            '{8'h00, 1'b0, ROW_MODEL, '0},
            '{8'h00, 1'b0, ROW_MODEL, '0},
            '{8'h80, 1'b0, ROW_MODEL, '0},
            '{8'h00, 1'b0, ROW_MODEL, '0},
            '{8'hFF, 1'b0, ROW_MODEL, '0},
            '{8'h01, 1'b0, ROW_MODEL, '0},
            '{8'h80, 1'b0, ROW_MODEL, '0},
            '{8'h7F, 1'b0, ROW_MODEL, '0},
            '{8'h55, 1'b0, ROW_MODEL, '0},
            '{8'hAA, 1'b0, ROW_MODEL, '0},
            '{8'h0F, 1'b0, ROW_MODEL, '0},
            '{8'hF0, 1'b0, ROW_MODEL, '0},
            '{8'h3C, 1'b0, ROW_MODEL, '0},
            '{8'hB7, 1'b0, ROW_TYPED, SUM_FIRST},
            '{8'h34, 1'b1, ROW_MODEL, '0},
            '{8'h12, 1'b0, ROW_MODEL, '0},
            '{8'h00, 1'b1, ROW_TYPED, TRUNC_TGT},
            '{8'h00, 1'b0, ROW_MODEL, '0},
            '{8'hAB, 1'b0, ROW_MODEL, '0},
            '{8'h77, 1'b1, ROW_TYPED, TRUNC_SRC}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].chk,
                      dir_rows[i].res);
        end
        drain_wait();

        // mostly whole frames, some cut short, some stray bytes
        while (accepted_count < N_ITEMS) begin
            if (!hold_done && accepted_count >= 350) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && accepted_count >= 800) begin
                drain_wait();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(FRAME_BYTES, $urandom_range(0, 3) != 0);
            end else if (pick < 9) begin
                send_frame($urandom_range(1, FRAME_BYTES - 1), 1'b1);
            end else begin
                repeat ($urandom_range(1, 3)) offer(rand_byte(), 1'b0);
            end
        end

        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("fixed_frame_parser_sum_checksum_top test passed");
        end else begin
            $display("fixed_frame_parser_sum_checksum_top test failed");
        end
        $finish;
    end

endmodule

### fixed_frame_parser_sum_checksum_top.f
rtl/ffpsc_pkg.sv
rtl/ffpsc_in_stage.sv
rtl/ffpsc_core.sv
rtl/ffpsc_out_stage.sv
rtl/fixed_frame_parser_sum_checksum_top.sv
tb/tb.sv
